[rtl/core/assert_macros.svh]
// Assertion macros used by the fan relay sequencer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Checks that the antecedent implies the consequent in the same cycle.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the antecedent implies the consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/fan_rs_pkg.sv]
// Shared types and constants for the fan relay sequencer.
package fan_rs_pkg;

  // Operation codes of an input item.
  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_ON   = 2'd1;
  localparam logic [1:0] OP_OFF  = 2'd2;

  // User-visible state codes.
  localparam logic [2:0] US_OFF    = 3'd0;
  localparam logic [2:0] US_AUX_ON = 3'd1;
  localparam logic [2:0] US_FAN_ON = 3'd2;
  localparam logic [2:0] US_FAULT  = 3'd3;
  localparam logic [2:0] US_NA     = 3'd4;

  // Configuration port geometry and register indexes.
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;
  localparam logic [CFG_IDX_W-1:0] REG_UNIT_ENABLED = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MULTI_UNIT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAIN_DELAY   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RETRY_WAIT   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SIM_ENABLE   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SIM_FAIL     = 3'd7;

  // Register reset values.
  localparam logic        RST_UNIT_ENABLED = 1'b1;
  localparam logic        RST_MULTI_UNIT   = 1'b1;
  localparam logic [15:0] RST_MAIN_DELAY   = 16'd10;
  localparam logic [7:0]  RST_SETTLE       = 8'd2;
  localparam logic [15:0] RST_DEBOUNCE     = 16'd1;
  localparam logic [15:0] RST_RETRY_WAIT   = 16'd30;
  localparam logic        RST_SIM_ENABLE   = 1'b0;
  localparam logic        RST_SIM_FAIL     = 1'b0;

  // Configuration register set.
  typedef struct packed {
    logic        unit_enabled;
    logic        multi_unit;
    logic [15:0] main_on_delay;
    logic [7:0]  settle_ticks;
    logic [15:0] debounce_ticks;
    logic [15:0] retry_wait_ticks;
    logic        sim_enable;
    logic        sim_fail;
  } cfg_t;

  // One input item.
  typedef struct packed {
    logic [1:0]  operation;
    logic        feedback_level;
    logic [31:0] tick_now;
  } item_t;

  // One result item.
  typedef struct packed {
    logic       main_relay_on;
    logic       aux_relay_on;
    logic       status_led_on;
    logic [2:0] user_state;
    logic       in_fault;
  } res_t;

endpackage

[rtl/core/fan_rs_if.sv]
// Valid/ready channel interfaces for the fan relay sequencer.
interface fan_rs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic        feedback_level;
  logic [31:0] tick_now;

  modport source (output valid, output operation, output feedback_level,
                  output tick_now, input ready);
  modport sink (input valid, input operation, input feedback_level,
                input tick_now, output ready);
endinterface

interface fan_rs_out_if;
  logic       valid;
  logic       ready;
  logic       main_relay_on;
  logic       aux_relay_on;
  logic       status_led_on;
  logic [2:0] user_state;
  logic       in_fault;

  modport source (output valid, output main_relay_on, output aux_relay_on,
                  output status_led_on, output user_state, output in_fault,
                  input ready);
  modport sink (input valid, input main_relay_on, input aux_relay_on,
                input status_led_on, input user_state, input in_fault,
                output ready);
endinterface

[rtl/core/fan_rs_cfg.sv]
// Configuration register file of the fan relay sequencer.
module fan_rs_cfg
  import fan_rs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  // Each write lands in the register that the index selects.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.unit_enabled     <= RST_UNIT_ENABLED;
      cfg_r.multi_unit       <= RST_MULTI_UNIT;
      cfg_r.main_on_delay    <= RST_MAIN_DELAY;
      cfg_r.settle_ticks     <= RST_SETTLE;
      cfg_r.debounce_ticks   <= RST_DEBOUNCE;
      cfg_r.retry_wait_ticks <= RST_RETRY_WAIT;
      cfg_r.sim_enable       <= RST_SIM_ENABLE;
      cfg_r.sim_fail         <= RST_SIM_FAIL;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_UNIT_ENABLED: cfg_r.unit_enabled     <= cfg_data[0];
        REG_MULTI_UNIT:   cfg_r.multi_unit       <= cfg_data[0];
        REG_MAIN_DELAY:   cfg_r.main_on_delay    <= cfg_data[15:0];
        REG_SETTLE:       cfg_r.settle_ticks     <= cfg_data[7:0];
        REG_DEBOUNCE:     cfg_r.debounce_ticks   <= cfg_data[15:0];
        REG_RETRY_WAIT:   cfg_r.retry_wait_ticks <= cfg_data[15:0];
        REG_SIM_ENABLE:   cfg_r.sim_enable       <= cfg_data[0];
        REG_SIM_FAIL:     cfg_r.sim_fail         <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

[rtl/core/fan_rs_deb.sv]
// Debouncer for the AC feedback level, stepped once per tick item.
module fan_rs_deb
  import fan_rs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic        level,
  input  logic [31:0] now,
  input  logic [15:0] debounce_ticks,
  output logic        fb_high_nxt
);

  typedef enum logic [2:0] {
    FB_UNKNOWN,
    FB_TO_HIGH,
    FB_HIGH,
    FB_TO_LOW,
    FB_LOW
  } fb_state_t;

  fb_state_t   fb_r, fb_nxt, fb_step;
  logic [31:0] high_since_r, high_since_nxt;
  logic [31:0] low_since_r, low_since_nxt;
  logic [31:0] high_elapsed, low_elapsed;

  // Wrapping elapsed time since each edge was seen.
  assign high_elapsed = now - high_since_r;
  assign low_elapsed  = now - low_since_r;

  // Next debouncer state for a tick.
  always_comb begin
    fb_step        = fb_r;
    high_since_nxt = high_since_r;
    low_since_nxt  = low_since_r;
    case (fb_r)
      FB_TO_HIGH: begin
        if (level) begin
          if (high_elapsed >= {16'd0, debounce_ticks}) fb_step = FB_HIGH;
        end else begin
          fb_step = FB_LOW;
        end
      end
      FB_HIGH: begin
        if (!level) begin
          low_since_nxt = now;
          fb_step       = FB_TO_LOW;
        end
      end
      FB_TO_LOW: begin
        if (!level) begin
          if (low_elapsed >= {16'd0, debounce_ticks}) fb_step = FB_LOW;
        end else begin
          fb_step = FB_HIGH;
        end
      end
      FB_LOW: begin
        if (level) begin
          high_since_nxt = now;
          fb_step        = FB_TO_HIGH;
        end
      end
      default: begin
        if (level) begin
          high_since_nxt = now;
          fb_step        = FB_TO_HIGH;
        end else begin
          low_since_nxt = now;
          fb_step       = FB_TO_LOW;
        end
      end
    endcase
  end

  assign fb_nxt      = step ? fb_step : fb_r;
  assign fb_high_nxt = (fb_nxt == FB_HIGH);

  // State and edge timestamps.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fb_r         <= FB_UNKNOWN;
      high_since_r <= 32'd0;
      low_since_r  <= 32'd0;
    end else if (step) begin
      fb_r         <= fb_step;
      high_since_r <= high_since_nxt;
      low_since_r  <= low_since_nxt;
    end
  end

endmodule

[rtl/core/fan_rs_seq.sv]
// Relay sequencer with fault dwell and restart, plus result formatting.
`include "assert_macros.svh"

module fan_rs_seq
  import fan_rs_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  step,
  input  item_t item,
  input  cfg_t  cfg,
  input  logic  fb_high_nxt,
  output res_t  res
);

  typedef enum logic [2:0] {
    RS_OFF,
    RS_TURN_AUX,
    RS_AUX_ON,
    RS_WAIT_MAIN,
    RS_MAIN_ON,
    RS_AT_FAULT,
    RS_CLEARING,
    RS_TURN_OFF
  } run_state_t;

  typedef enum logic [2:0] {
    CP_IDLE,
    CP_TURN_AUX,
    CP_AUX_ON,
    CP_WAIT_MAIN,
    CP_MAIN_ON
  } clear_phase_t;

  run_state_t   run_r, run_nxt;
  clear_phase_t cp_r, cp_nxt;
  logic [15:0]  cnt_r, cnt_nxt, cnt_inc;
  logic         main_r, main_nxt;
  logic         aux_r, aux_nxt;
  logic         led_r, led_nxt;
  logic         fault;

  // Saturating step counter increment.
  assign cnt_inc = (cnt_r == 16'hFFFF) ? cnt_r : cnt_r + 16'd1;

  // Unless sim_enable is set, the fault decision uses the feedback status after this item's debounce step.
  assign fault = cfg.sim_enable ? cfg.sim_fail : fb_high_nxt;

  // Next state for one item.
  always_comb begin
    run_nxt  = run_r;
    cp_nxt   = cp_r;
    cnt_nxt  = cnt_r;
    main_nxt = main_r;
    aux_nxt  = aux_r;
    led_nxt  = led_r;
    case (item.operation)
      OP_TICK: begin
        case (run_r)
          RS_TURN_AUX: begin
            aux_nxt = 1'b1;
            led_nxt = 1'b1;
            run_nxt = RS_AUX_ON;
          end
          RS_AUX_ON: begin
            cnt_nxt = cnt_inc;
            if (cnt_inc >= cfg.main_on_delay) begin
              main_nxt = 1'b1;
              run_nxt  = RS_WAIT_MAIN;
              cnt_nxt  = 16'd0;
            end
          end
          RS_WAIT_MAIN: begin
            cnt_nxt = cnt_inc;
            if (cnt_inc >= {8'd0, cfg.settle_ticks}) begin
              run_nxt = RS_MAIN_ON;
              cnt_nxt = 16'd0;
            end
          end
          RS_MAIN_ON: begin
            if (fault) begin
              run_nxt = RS_AT_FAULT;
              cnt_nxt = 16'd0;
            end
          end
          RS_AT_FAULT: begin
            cnt_nxt = cnt_inc;
            if (cnt_inc > cfg.retry_wait_ticks && cp_r != CP_IDLE) begin
              run_nxt = RS_CLEARING;
            end else begin
              cp_nxt   = CP_TURN_AUX;
              main_nxt = 1'b0;
              led_nxt  = 1'b0;
              aux_nxt  = 1'b0;
            end
          end
          RS_CLEARING: begin
            // The restart walks the same aux-then-main order as a normal start.
            case (cp_r)
              CP_TURN_AUX: begin
                aux_nxt = 1'b1;
                led_nxt = 1'b1;
                cp_nxt  = CP_AUX_ON;
              end
              CP_AUX_ON: begin
                cnt_nxt = cnt_inc;
                if (cnt_inc >= cfg.main_on_delay) begin
                  main_nxt = 1'b1;
                  cp_nxt   = CP_WAIT_MAIN;
                  cnt_nxt  = 16'd0;
                end
              end
              CP_WAIT_MAIN: begin
                cnt_nxt = cnt_inc;
                if (cnt_inc >= {8'd0, cfg.settle_ticks}) begin
                  cp_nxt  = CP_MAIN_ON;
                  cnt_nxt = 16'd0;
                end
              end
              CP_MAIN_ON: begin
                if (fault) begin
                  run_nxt = RS_AT_FAULT;
                end else begin
                  run_nxt  = RS_OFF;
                  cp_nxt   = CP_IDLE;
                  main_nxt = 1'b0;
                  led_nxt  = 1'b0;
                  aux_nxt  = 1'b0;
                end
              end
              default: run_nxt = RS_OFF;
            endcase
          end
          RS_TURN_OFF: begin
            main_nxt = 1'b0;
            led_nxt  = 1'b0;
            aux_nxt  = 1'b0;
            run_nxt  = RS_OFF;
          end
          default: ;
        endcase
      end
      OP_ON: begin
        if (cfg.unit_enabled && run_r == RS_OFF) run_nxt = RS_TURN_AUX;
      end
      OP_OFF: begin
        if (cfg.unit_enabled && (run_r == RS_AUX_ON || run_r == RS_MAIN_ON)) begin
          run_nxt = RS_TURN_OFF;
        end
      end
      default: ;
    endcase
  end

  // Result fields reflect the state after this item.
  always_comb begin
    res.main_relay_on = main_nxt;
    res.aux_relay_on  = aux_nxt;
    res.status_led_on = led_nxt;
    res.in_fault      = fault;
    if (!cfg.multi_unit) begin
      res.user_state = US_NA;
    end else begin
      case (run_nxt)
        RS_TURN_AUX, RS_AUX_ON:  res.user_state = US_AUX_ON;
        RS_WAIT_MAIN, RS_MAIN_ON: res.user_state = US_FAN_ON;
        RS_AT_FAULT, RS_CLEARING: res.user_state = US_FAULT;
        default:                  res.user_state = US_OFF;
      endcase
    end
  end

  // Sequencer state and relay drive registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= RS_OFF;
      cp_r   <= CP_IDLE;
      cnt_r  <= 16'd0;
      main_r <= 1'b0;
      aux_r  <= 1'b0;
      led_r  <= 1'b0;
    end else if (step) begin
      run_r  <= run_nxt;
      cp_r   <= cp_nxt;
      cnt_r  <= cnt_nxt;
      main_r <= main_nxt;
      aux_r  <= aux_nxt;
      led_r  <= led_nxt;
    end
  end

  // The main relay never closes without the aux relay.
  `ASSERT_IMPLY(a_main_needs_aux, main_r, aux_r, "main relay closed while aux relay open")
  // The status LED is lit only with the aux relay closed.
  `ASSERT_IMPLY(a_led_needs_aux, led_r, aux_r, "status LED on while aux relay open")
  // A restart always has a phase to run.
  `ASSERT_IMPLY(a_clear_phase, run_r == RS_CLEARING, cp_r != CP_IDLE,
                "restart state with idle restart phase")
  // A request item never moves the relays.
  `ASSERT_NEXT(a_req_no_relay, step && item.operation != OP_TICK,
               $stable(main_r) && $stable(aux_r) && $stable(led_r),
               "relay levels changed on a request item")

endmodule

[rtl/core/fan_relay_sequencer_with_fault_retry.sv]
// Top level of the fan relay sequencer with fault retry.
//
// Usage: each input item on in_ch is a tick (with the AC feedback level and the
// system tick count) or an on/off request. Every accepted item yields exactly one
// result item on out_ch with the relay and LED levels, the user-visible state and
// the current fault decision, in input order.
// Configuration is written through cfg_we/cfg_idx/cfg_data, one register per
// cycle, while no item is in flight.
// Path: an accepted item is held in the input register, runs through the
// sequencer logic and is loaded into the result register once that register is
// free or being emptied; it is offered on out_ch from then on.
// Throughput: one item per cycle unless out_ch stalls; sequencer state updates in one pass.
// When out_ch stalls, the result register holds its item and the input register
// still takes one more item; after that in_ch.ready drops until out_ch drains.
// Reset (rst_n low, synchronous) opens both relays, turns off the LED, clears the
// debouncer and counters, loads the register defaults and empties both stages.
module fan_relay_sequencer_with_fault_retry
  import fan_rs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  fan_rs_in_if.sink             in_ch,
  fan_rs_out_if.source          out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t  cfg;
  item_t item_r;
  res_t  res, res_r;
  logic  in_v_r, out_v_r;
  logic  adv, is_tick, fb_high_nxt;

  // An item moves on when the result register is free or being emptied.
  assign adv         = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !in_v_r || adv;
  assign is_tick     = adv && (item_r.operation == OP_TICK);

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.operation      <= in_ch.operation;
      item_r.feedback_level <= in_ch.feedback_level;
      item_r.tick_now       <= in_ch.tick_now;
    end
  end

  fan_rs_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  fan_rs_deb u_deb (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (is_tick),
    .level          (item_r.feedback_level),
    .now            (item_r.tick_now),
    .debounce_ticks (cfg.debounce_ticks),
    .fb_high_nxt    (fb_high_nxt)
  );

  fan_rs_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (adv),
    .item        (item_r),
    .cfg         (cfg),
    .fb_high_nxt (fb_high_nxt),
    .res         (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) res_r <= res;
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.main_relay_on = res_r.main_relay_on;
  assign out_ch.aux_relay_on  = res_r.aux_relay_on;
  assign out_ch.status_led_on = res_r.status_led_on;
  assign out_ch.user_state    = res_r.user_state;
  assign out_ch.in_fault      = res_r.in_fault;

endmodule

[bench/tb.sv]
// Self-checking testbench for the fan relay sequencer with fault retry.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fan_rs_pkg::*;

  // The one operation code the block treats as a no-op.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 80;
  localparam int MAX_PRINTS = 40;

  // Sequencer, retry and debounce states of the predictor.
  typedef enum logic [2:0] {
    RUN_OFF, RUN_TURN_AUX, RUN_AUX_ON, RUN_WAIT_MAIN,
    RUN_MAIN_ON, RUN_AT_FAULT, RUN_CLEARING, RUN_TURN_OFF
  } run_e;
  typedef enum logic [2:0] {
    RETRY_IDLE, RETRY_TURN_AUX, RETRY_AUX_ON, RETRY_WAIT_MAIN, RETRY_MAIN_ON
  } retry_e;
  typedef enum logic [2:0] {
    FB_UNKNOWN, FB_TO_HIGH, FB_HIGH, FB_TO_LOW, FB_LOW
  } fb_e;

  // One row of the directed stimulus table.
  typedef struct packed {
    item_t it;
    logic  typed;
    res_t  want;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  fan_rs_in_if  in_if ();
  fan_rs_out_if out_if ();

  fan_relay_sequencer_with_fault_retry uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_if),
    .out_ch   (out_if),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  // Predictor state and its copy of the registers.
  cfg_t        m_cfg;
  run_e        m_run;
  retry_e      m_retry;
  fb_e         m_fb;
  logic [15:0] m_count;
  logic [31:0] m_high_since;
  logic [31:0] m_low_since;
  logic        m_main;
  logic        m_aux;
  logic        m_led;

  // Expected results (relay and LED levels, state, fault), oldest first.
  res_t levels_due[$];

  // Random stimulus state and run bookkeeping.
  logic [31:0] t_now;
  logic        fb_lvl;
  bit          back_to_back;
  bit          hold_outputs;
  int          mismatches;
  int          items_sent;
  int          results_checked;
  int          settings_used;
  int          fault_entries;
  int          retries;
  int          holds_done;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Generous bound: the slowest correct run is well under two milliseconds.
  initial begin
    #(10_000_000);
    $display("Test completed with failures");
    $finish;
  end

  task automatic report_mismatch(input string field, input int idx, input int got,
                                 input int want);
    if (mismatches < MAX_PRINTS)
      $display("Result %0d: %s is %0d, expected %0d", idx, field, got, want);
    mismatches++;
  endtask

  function automatic logic fault_seen();
    return m_cfg.sim_enable ? m_cfg.sim_fail : (m_fb == FB_HIGH);
  endfunction

  function automatic void bump_count();
    if (m_count != 16'hFFFF) m_count = m_count + 16'd1;
  endfunction

  function automatic void close_aux();
    m_aux = 1'b1;
    m_led = 1'b1;
  endfunction

  function automatic void drop_relays();
    m_main = 1'b0;
    m_led  = 1'b0;
    m_aux  = 1'b0;
  endfunction

  // Advances the predictor by one item and returns the levels it reports.
  function automatic res_t predict_levels(input item_t it);
    res_t r;
    logic [31:0] held;
    case (it.operation)
      OP_TICK: begin
        // Feedback debounce runs once per tick, ahead of the sequencer step.
        case (m_fb)
          FB_TO_HIGH: begin
            held = it.tick_now - m_high_since;
            if (!it.feedback_level) m_fb = FB_LOW;
            else if (held >= {16'd0, m_cfg.debounce_ticks}) m_fb = FB_HIGH;
          end
          FB_HIGH: begin
            if (!it.feedback_level) begin
              m_low_since = it.tick_now;
              m_fb = FB_TO_LOW;
            end
          end
          FB_TO_LOW: begin
            held = it.tick_now - m_low_since;
            if (it.feedback_level) m_fb = FB_HIGH;
            else if (held >= {16'd0, m_cfg.debounce_ticks}) m_fb = FB_LOW;
          end
          FB_LOW: begin
            if (it.feedback_level) begin
              m_high_since = it.tick_now;
              m_fb = FB_TO_HIGH;
            end
          end
          default: begin
            if (it.feedback_level) begin
              m_high_since = it.tick_now;
              m_fb = FB_TO_HIGH;
            end else begin
              m_low_since = it.tick_now;
              m_fb = FB_TO_LOW;
            end
          end
        endcase

        // Sequencer step.
        case (m_run)
          RUN_TURN_AUX: begin
            close_aux();
            m_run = RUN_AUX_ON;
          end
          RUN_AUX_ON: begin
            bump_count();
            if (m_count >= m_cfg.main_on_delay) begin
              m_main  = 1'b1;
              m_run   = RUN_WAIT_MAIN;
              m_count = '0;
            end
          end
          RUN_WAIT_MAIN: begin
            bump_count();
            if (m_count >= {8'd0, m_cfg.settle_ticks}) begin
              m_run   = RUN_MAIN_ON;
              m_count = '0;
            end
          end
          RUN_MAIN_ON: begin
            if (fault_seen()) begin
              m_run   = RUN_AT_FAULT;
              m_count = '0;
              fault_entries++;
            end
          end
          RUN_AT_FAULT: begin
            // The dwell count keeps running; the first fault tick arms the retry.
            bump_count();
            if (m_count > m_cfg.retry_wait_ticks && m_retry != RETRY_IDLE) begin
              m_run = RUN_CLEARING;
              retries++;
            end else begin
              m_retry = RETRY_TURN_AUX;
              drop_relays();
            end
          end
          RUN_CLEARING: begin
            // The retry repeats the aux-then-main start without clearing the count.
            case (m_retry)
              RETRY_IDLE: m_run = RUN_OFF;
              RETRY_TURN_AUX: begin
                close_aux();
                m_retry = RETRY_AUX_ON;
              end
              RETRY_AUX_ON: begin
                bump_count();
                if (m_count >= m_cfg.main_on_delay) begin
                  m_main  = 1'b1;
                  m_retry = RETRY_WAIT_MAIN;
                  m_count = '0;
                end
              end
              RETRY_WAIT_MAIN: begin
                bump_count();
                if (m_count >= {8'd0, m_cfg.settle_ticks}) begin
                  m_retry = RETRY_MAIN_ON;
                  m_count = '0;
                end
              end
              RETRY_MAIN_ON: begin
                if (fault_seen()) begin
                  m_run = RUN_AT_FAULT;
                  fault_entries++;
                end else begin
                  m_run   = RUN_OFF;
                  m_retry = RETRY_IDLE;
                  drop_relays();
                end
              end
              default: ;
            endcase
          end
          RUN_TURN_OFF: begin
            drop_relays();
            m_run = RUN_OFF;
          end
          default: ;
        endcase
      end
      OP_ON: begin
        if (m_cfg.unit_enabled && m_run == RUN_OFF) m_run = RUN_TURN_AUX;
      end
      OP_OFF: begin
        if (m_cfg.unit_enabled && (m_run == RUN_AUX_ON || m_run == RUN_MAIN_ON))
          m_run = RUN_TURN_OFF;
      end
      default: ;
    endcase

    r.main_relay_on = m_main;
    r.aux_relay_on  = m_aux;
    r.status_led_on = m_led;
    r.in_fault      = fault_seen();
    if (!m_cfg.multi_unit) begin
      r.user_state = US_NA;
    end else begin
      case (m_run)
        RUN_TURN_AUX, RUN_AUX_ON:  r.user_state = US_AUX_ON;
        RUN_WAIT_MAIN, RUN_MAIN_ON: r.user_state = US_FAN_ON;
        RUN_AT_FAULT, RUN_CLEARING: r.user_state = US_FAULT;
        default:                    r.user_state = US_OFF;
      endcase
    end
    return r;
  endfunction

  // Builds an item of the given operation with a drifting tick count and feedback.
  function automatic item_t next_item(input logic [1:0] op);
    item_t it;
    if ($urandom_range(0, 99) < 12) fb_lvl = ~fb_lvl;
    if ($urandom_range(0, 99) < 4) t_now = $urandom();
    else t_now = t_now + 32'($urandom_range(0, 3));
    it.operation      = op;
    it.feedback_level = fb_lvl;
    it.tick_now       = t_now;
    return it;
  endfunction

  // Offers one item after a random gap and records what it should produce.
  task automatic send_item(input item_t it, input logic typed, input res_t want);
    int gap;
    res_t predicted;
    gap = back_to_back ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_if.valid          <= 1'b1;
    in_if.operation      <= it.operation;
    in_if.feedback_level <= it.feedback_level;
    in_if.tick_now       <= it.tick_now;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    predicted = predict_levels(it);
    levels_due.push_back(typed ? want : predicted);
    items_sent++;
  endtask

  // Stops offering items and waits until every result has come back.
  task automatic drain();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (levels_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    case (idx)
      REG_UNIT_ENABLED: m_cfg.unit_enabled     = val[0];
      REG_MULTI_UNIT:   m_cfg.multi_unit       = val[0];
      REG_MAIN_DELAY:   m_cfg.main_on_delay    = val;
      REG_SETTLE:       m_cfg.settle_ticks     = val[7:0];
      REG_DEBOUNCE:     m_cfg.debounce_ticks   = val;
      REG_RETRY_WAIT:   m_cfg.retry_wait_ticks = val;
      REG_SIM_ENABLE:   m_cfg.sim_enable       = val[0];
      REG_SIM_FAIL:     m_cfg.sim_fail         = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Loads a full register setting once the block has gone quiet.
  task automatic apply_setting(input cfg_t c);
    drain();
    write_reg(REG_UNIT_ENABLED, {15'd0, c.unit_enabled});
    write_reg(REG_MULTI_UNIT, {15'd0, c.multi_unit});
    write_reg(REG_MAIN_DELAY, c.main_on_delay);
    write_reg(REG_SETTLE, {8'd0, c.settle_ticks});
    write_reg(REG_DEBOUNCE, c.debounce_ticks);
    write_reg(REG_RETRY_WAIT, c.retry_wait_ticks);
    write_reg(REG_SIM_ENABLE, {15'd0, c.sim_enable});
    write_reg(REG_SIM_FAIL, {15'd0, c.sim_fail});
    settings_used++;
  endtask

  // Mostly ticks with on, off and no-op items mixed in unless ticks_only is set, so full start and retry runs occur.
  task automatic run_phase(input int count, input bit ticks_only);
    int pick;
    logic [1:0] op;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (ticks_only || pick >= 16) op = OP_TICK;
      else if (pick < 8) op = OP_ON;
      else if (pick < 14) op = OP_OFF;
      else op = OP_UNUSED;
      send_item(next_item(op), 1'b0, '0);
    end
  endtask

  // Result side: random stalls, one long hold on request, field-by-field check.
  initial begin : result_sink
    int pause;
    res_t got;
    res_t want;
    out_if.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      pause = back_to_back ? 0 : $urandom_range(0, 17);
      if (hold_outputs) begin
        hold_outputs = 1'b0;
        pause = HOLD_CYCLES;
        holds_done++;
      end
      if (pause > 0) begin
        @(negedge clk);
        out_if.ready <= 1'b0;
        repeat (pause - 1) @(negedge clk);
      end
      @(negedge clk);
      out_if.ready <= 1'b1;
      @(posedge clk);
      while (!out_if.valid) @(posedge clk);
      got.main_relay_on = out_if.main_relay_on;
      got.aux_relay_on  = out_if.aux_relay_on;
      got.status_led_on = out_if.status_led_on;
      got.user_state    = out_if.user_state;
      got.in_fault      = out_if.in_fault;
      if (levels_due.size() == 0) begin
        report_mismatch("unexpected result, user_state", results_checked,
                        got.user_state, 0);
      end else begin
        want = levels_due.pop_front();
        if (got.main_relay_on !== want.main_relay_on)
          report_mismatch("main_relay_on", results_checked, got.main_relay_on,
                          want.main_relay_on);
        if (got.aux_relay_on !== want.aux_relay_on)
          report_mismatch("aux_relay_on", results_checked, got.aux_relay_on,
                          want.aux_relay_on);
        if (got.status_led_on !== want.status_led_on)
          report_mismatch("status_led_on", results_checked, got.status_led_on,
                          want.status_led_on);
        if (got.user_state !== want.user_state)
          report_mismatch("user_state", results_checked, got.user_state,
                          want.user_state);
        if (got.in_fault !== want.in_fault)
          report_mismatch("in_fault", results_checked, got.in_fault, want.in_fault);
      end
      results_checked++;
    end
  end

  initial begin : stimulus
    dir_row_t rows[$];
    dir_row_t row;
    res_t all_off;

    // Every input known from time zero, with reset asserted.
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_idx              = '0;
    cfg_data             = '0;
    in_if.valid          = 1'b0;
    in_if.operation      = OP_TICK;
    in_if.feedback_level = 1'b0;
    in_if.tick_now       = '0;
    back_to_back         = 1'b0;
    hold_outputs         = 1'b0;
    t_now                = '0;
    fb_lvl               = 1'b0;

    m_cfg = '{unit_enabled: RST_UNIT_ENABLED, multi_unit: RST_MULTI_UNIT,
              main_on_delay: RST_MAIN_DELAY, settle_ticks: RST_SETTLE,
              debounce_ticks: RST_DEBOUNCE, retry_wait_ticks: RST_RETRY_WAIT,
              sim_enable: RST_SIM_ENABLE, sim_fail: RST_SIM_FAIL};
    m_run        = RUN_OFF;
    m_retry      = RETRY_IDLE;
    m_fb         = FB_UNKNOWN;
    m_count      = '0;
    m_high_since = '0;
    m_low_since  = '0;
    m_main       = 1'b0;
    m_aux        = 1'b0;
    m_led        = 1'b0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table on the reset setting: idle reports, the no-op code, ignored
    // requests, an off request in the aux phase, a wrapping debounce interval,
    // then a full start that runs into a feedback fault.
    all_off = res_t'({1'b0, 1'b0, 1'b0, US_OFF, 1'b0});
    rows.push_back('{it: '{OP_TICK, 1'b0, 32'h0000_0000}, typed: 1'b1, want: all_off});
    rows.push_back('{it: '{OP_UNUSED, 1'b1, 32'hFFFF_FFFF}, typed: 1'b1, want: all_off});
    rows.push_back('{it: '{OP_OFF, 1'b1, 32'hFFFF_FFFF}, typed: 1'b1, want: all_off});
    rows.push_back('{it: '{OP_ON, 1'b0, 32'h0000_0000}, typed: 1'b1,
                     want: res_t'({1'b0, 1'b0, 1'b0, US_AUX_ON, 1'b0})});
    rows.push_back('{it: '{OP_ON, 1'b0, 32'h0000_0000}, typed: 1'b1,
                     want: res_t'({1'b0, 1'b0, 1'b0, US_AUX_ON, 1'b0})});
    rows.push_back('{it: '{OP_TICK, 1'b0, 32'h0000_0001}, typed: 1'b1,
                     want: res_t'({1'b0, 1'b1, 1'b1, US_AUX_ON, 1'b0})});
    rows.push_back('{it: '{OP_OFF, 1'b1, 32'h0000_0000}, typed: 1'b1,
                     want: res_t'({1'b0, 1'b1, 1'b1, US_OFF, 1'b0})});
    rows.push_back('{it: '{OP_TICK, 1'b1, 32'hFFFF_FFFF}, typed: 1'b1, want: all_off});
    rows.push_back('{it: '{OP_TICK, 1'b1, 32'h0000_0000}, typed: 1'b1,
                     want: res_t'({1'b0, 1'b0, 1'b0, US_OFF, 1'b1})});
    rows.push_back('{it: '{OP_ON, 1'b0, 32'h0000_0000}, typed: 1'b1,
                     want: res_t'({1'b0, 1'b0, 1'b0, US_AUX_ON, 1'b1})});
    for (int k = 0; k < 15; k++)
      rows.push_back('{it: '{OP_TICK, 1'b1, 32'h5555_AAA0 + 32'(k)}, typed: 1'b0,
                       want: '0});
    foreach (rows[i]) begin
      row = rows[i];
      send_item(row.it, row.typed, row.want);
    end

    // Short delays with feedback faults and retries.
    apply_setting('{unit_enabled: 1'b1, multi_unit: 1'b1, main_on_delay: 16'd3,
                    settle_ticks: 8'd1, debounce_ticks: 16'd2, retry_wait_ticks: 16'd4,
                    sim_enable: 1'b0, sim_fail: 1'b0});
    run_phase(400, 1'b0);

    // Zero delays, back to back, with one long output hold that backs up the input.
    apply_setting('{unit_enabled: 1'b1, multi_unit: 1'b1, main_on_delay: 16'd0,
                    settle_ticks: 8'd0, debounce_ticks: 16'd0, retry_wait_ticks: 16'd0,
                    sim_enable: 1'b0, sim_fail: 1'b0});
    back_to_back = 1'b1;
    hold_outputs = 1'b1;
    run_phase(250, 1'b0);
    back_to_back = 1'b0;

    // Simulated fault: every retry fails and re-enters the fault.
    apply_setting('{unit_enabled: 1'b1, multi_unit: 1'b1, main_on_delay: 16'd2,
                    settle_ticks: 8'd2, debounce_ticks: 16'hFFFF, retry_wait_ticks: 16'd3,
                    sim_enable: 1'b1, sim_fail: 1'b1});
    run_phase(250, 1'b0);

    // Simulated fault cleared: retries end in off; single unit hides the state.
    apply_setting('{unit_enabled: 1'b1, multi_unit: 1'b0, main_on_delay: 16'd1,
                    settle_ticks: 8'd1, debounce_ticks: 16'd1, retry_wait_ticks: 16'd2,
                    sim_enable: 1'b1, sim_fail: 1'b0});
    run_phase(200, 1'b0);

    // Unit disabled with the largest delays: requests are ignored.
    apply_setting('{unit_enabled: 1'b0, multi_unit: 1'b1, main_on_delay: 16'hFFFF,
                    settle_ticks: 8'hFF, debounce_ticks: 16'd1, retry_wait_ticks: 16'hFFFF,
                    sim_enable: 1'b0, sim_fail: 1'b1});
    run_phase(150, 1'b0);

    // Tick count starting just below the wrap point.
    apply_setting('{unit_enabled: 1'b1, multi_unit: 1'b1, main_on_delay: 16'd5,
                    settle_ticks: 8'd3, debounce_ticks: 16'd3, retry_wait_ticks: 16'd6,
                    sim_enable: 1'b0, sim_fail: 1'b0});
    t_now = 32'hFFFF_FFF0;
    run_phase(300, 1'b0);

    // Park the block in a fault whose dwell never ends.
    apply_setting('{unit_enabled: 1'b1, multi_unit: 1'b1, main_on_delay: 16'd1,
                    settle_ticks: 8'd1, debounce_ticks: 16'd1, retry_wait_ticks: 16'hFFFF,
                    sim_enable: 1'b1, sim_fail: 1'b1});
    for (int k = 0; k < 10; k++) begin
      send_item(next_item(OP_ON), 1'b0, '0);
      send_item(next_item(OP_TICK), 1'b0, '0);
    end
    run_phase(10, 1'b1);

    // The dwell count ends one below the start delay, so each retry closes main on
    // its first aux tick.
    apply_setting('{unit_enabled: 1'b1, multi_unit: 1'b1, main_on_delay: 16'd12,
                    settle_ticks: 8'd1, debounce_ticks: 16'd1, retry_wait_ticks: 16'd10,
                    sim_enable: 1'b1, sim_fail: 1'b1});
    back_to_back = 1'b1;
    run_phase(150, 1'b1);
    back_to_back = 1'b0;

    drain();
    repeat (4) @(posedge clk);

    $display("Checked %0d results from %0d items over %0d register settings.",
             results_checked, items_sent, settings_used);
    $display("Fault entries: %0d, retries started: %0d, long output holds: %0d.",
             fault_entries, retries, holds_done);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
